// ===== design/cbom_pkg.sv =====
// ----------------------------------------------------------------------------
// cbom_pkg
// Shared types and constants for the CAN signal bit occupancy map.
// ----------------------------------------------------------------------------
package cbom_pkg;

  localparam int MAX_FRAME_BITS = 512;
  localparam int MAX_SIGNALS    = 64;
  localparam int LEN_CAP        = 512;

  localparam int ADDR_W  = $clog2(MAX_FRAME_BITS);
  localparam int CNT_W   = $clog2(MAX_FRAME_BITS + 1);
  localparam int LEN_W   = 10;
  localparam int IDX_W   = 6;
  localparam int BIT_W   = 12;  // sawtooth walk may run well past the frame
  localparam int MUXV_W  = 16;
  localparam int FBYTE_W = 7;
  localparam int CFGI_W  = 2;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MUX_STATIC = 2'd0,
    MUX_MUXOR  = 2'd1,
    MUX_MUXED  = 2'd2,
    MUX_BOTH   = 2'd3
  } mux_type_t;

  typedef enum logic [CFGI_W-1:0] {
    REG_FRAME_BYTES = 2'd0,
    REG_SHOW_ALL    = 2'd1,
    REG_SEL_MUX     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             owned;
    logic [IDX_W-1:0] owner;
    logic             ovl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_FLUSH,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic walk;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  add_skip;
    logic  walk_last;
    logic  sweep_last;
    logic  out_busy;
  } sts_t;

endpackage

// ===== design/cbom_ram.sv =====
// ----------------------------------------------------------------------------
// cbom_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/cbom_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbom_ctrl
// Sequencer: clearing sweeps, bit walk, read and result hand-off.
// ----------------------------------------------------------------------------
module cbom_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cbom_pkg::sts_t  sts,
  output cbom_pkg::cmd_t  cmd
);

  cbom_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbom_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cbom_pkg::ST_INIT: begin
        if (sts.sweep_last) state_next = cbom_pkg::ST_IDLE;
      end
      cbom_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (sts.kind)
            cbom_pkg::KIND_CLEAR: state_next = cbom_pkg::ST_CLEAR;
            cbom_pkg::KIND_ADD: begin
              state_next = sts.add_skip ? cbom_pkg::ST_DONE : cbom_pkg::ST_WALK;
            end
            cbom_pkg::KIND_READ:  state_next = cbom_pkg::ST_READ;
            default:              state_next = cbom_pkg::ST_DONE;
          endcase
        end
      end
      cbom_pkg::ST_CLEAR: begin
        if (sts.sweep_last) state_next = cbom_pkg::ST_DONE;
      end
      cbom_pkg::ST_WALK: begin
        if (sts.walk_last) state_next = cbom_pkg::ST_FLUSH;
      end
      cbom_pkg::ST_FLUSH: state_next = cbom_pkg::ST_DONE;
      cbom_pkg::ST_READ:  state_next = cbom_pkg::ST_DONE;
      cbom_pkg::ST_DONE: begin
        if (!sts.out_busy) state_next = cbom_pkg::ST_IDLE;
      end
      default: state_next = cbom_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready     = (state == cbom_pkg::ST_IDLE);
    cmd.accept   = (state == cbom_pkg::ST_IDLE) && in_valid;
    cmd.sweep    = (state == cbom_pkg::ST_INIT) || (state == cbom_pkg::ST_CLEAR);
    cmd.walk     = (state == cbom_pkg::ST_WALK);
    cmd.rd_issue = (state == cbom_pkg::ST_READ);
    cmd.load_out = (state == cbom_pkg::ST_DONE) && !sts.out_busy;
  end

endmodule

// ===== design/cbom_dp.sv =====
// ----------------------------------------------------------------------------
// cbom_dp
// Datapath: config registers, map RAM, bit walker, claim stage, result reg.
// ----------------------------------------------------------------------------
module cbom_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cbom_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [cbom_pkg::MUXV_W-1:0]  cfg_data,
  input  logic [1:0]                   kind,
  input  logic [cbom_pkg::IDX_W-1:0]   signal_index,
  input  logic [8:0]                   start_bit,
  input  logic [cbom_pkg::LEN_W-1:0]   bit_length,
  input  logic                         big_endian,
  input  logic [1:0]                   mux_type,
  input  logic [cbom_pkg::MUXV_W-1:0]  mux_value,
  input  logic [cbom_pkg::ADDR_W-1:0]  bit_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         owner_valid,
  output logic [cbom_pkg::IDX_W-1:0]   owner_index,
  output logic                         overlap,
  output logic [cbom_pkg::CNT_W-1:0]   used_bits,
  input  cbom_pkg::cmd_t               cmd,
  output cbom_pkg::sts_t               sts
);

  // configuration
  logic [cbom_pkg::FBYTE_W-1:0] frame_bytes;
  logic                         show_all;
  logic [cbom_pkg::MUXV_W-1:0]  sel_mux;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes <= cbom_pkg::FBYTE_W'(8);
      show_all    <= 1'b1;
      sel_mux     <= '0;
    end else if (cfg_we) begin
      unique case (cbom_pkg::reg_idx_t'(cfg_index))
        cbom_pkg::REG_FRAME_BYTES: frame_bytes <= cfg_data[cbom_pkg::FBYTE_W-1:0];
        cbom_pkg::REG_SHOW_ALL:    show_all    <= cfg_data[0];
        cbom_pkg::REG_SEL_MUX:     sel_mux     <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [cbom_pkg::CNT_W-1:0] fb_bits;
  logic [cbom_pkg::CNT_W-1:0] total;

  always_comb begin
    fb_bits = cbom_pkg::CNT_W'({frame_bytes, 3'b000});
    total   = (fb_bits > cbom_pkg::CNT_W'(cbom_pkg::MAX_FRAME_BITS)) ?
              cbom_pkg::CNT_W'(cbom_pkg::MAX_FRAME_BITS) : fb_bits;
  end

  // item decode at the input
  cbom_pkg::mux_type_t        in_mtype;
  logic                       hidden;
  logic [cbom_pkg::LEN_W-1:0] len_eff;

  always_comb begin
    in_mtype = cbom_pkg::mux_type_t'(mux_type);
    hidden   = !show_all && (in_mtype == cbom_pkg::MUX_MUXED ||
                             in_mtype == cbom_pkg::MUX_BOTH) && (mux_value != sel_mux);
    len_eff  = (bit_length > cbom_pkg::LEN_W'(cbom_pkg::LEN_CAP)) ?
               cbom_pkg::LEN_W'(cbom_pkg::LEN_CAP) : bit_length;
  end

  // latched item
  cbom_pkg::kind_t              item_kind;
  logic [cbom_pkg::IDX_W-1:0]   item_idx;
  logic                         item_big;
  logic [cbom_pkg::ADDR_W-1:0]  item_pos;
  logic [cbom_pkg::BIT_W-1:0]   bit_cur;
  logic [cbom_pkg::LEN_W-1:0]   remaining;
  logic [cbom_pkg::BIT_W-1:0]   cur_pos;
  logic                         cur_in_frame;

  always_comb begin
    // display position flips the bit within its byte
    cur_pos      = bit_cur ^ cbom_pkg::BIT_W'(7);
    cur_in_frame = cur_pos < cbom_pkg::BIT_W'(total);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= cbom_pkg::kind_t'(kind);
      item_idx  <= signal_index;
      item_big  <= big_endian;
      item_pos  <= bit_position;
      bit_cur   <= cbom_pkg::BIT_W'(start_bit);
      remaining <= len_eff;
    end else if (cmd.walk) begin
      remaining <= remaining - 1'b1;
      if (!item_big) begin
        bit_cur <= bit_cur + 1'b1;
      end else if (bit_cur[2:0] == 3'd0) begin
        bit_cur <= bit_cur + cbom_pkg::BIT_W'(15);
      end else begin
        bit_cur <= bit_cur - 1'b1;
      end
    end
  end

  // clearing sweep address
  logic [cbom_pkg::ADDR_W-1:0] sweep_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  // claim stage: read issued during walk, update in the next cycle
  logic                        s2_valid;
  logic [cbom_pkg::ADDR_W-1:0] s2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= cmd.walk && cur_in_frame;
    end
  end

  always_ff @(posedge clk) begin
    s2_pos <= cur_pos[cbom_pkg::ADDR_W-1:0];
  end

  logic [cbom_pkg::ENTRY_W-1:0] rdata;
  cbom_pkg::entry_t             rd_ent;
  cbom_pkg::entry_t             wr_ent;
  logic                         s2_write;
  logic                         s2_new;
  logic                         ram_we;
  logic [cbom_pkg::ADDR_W-1:0]  ram_waddr;
  logic [cbom_pkg::ADDR_W-1:0]  ram_raddr;

  always_comb begin
    rd_ent = cbom_pkg::entry_t'(rdata);
    s2_new = s2_valid && !rd_ent.owned;
    s2_write = s2_new || (s2_valid && rd_ent.owner != item_idx);
    if (cmd.sweep) begin
      wr_ent = '0;
    end else if (!rd_ent.owned) begin
      wr_ent = '{owned: 1'b1, owner: item_idx, ovl: 1'b0};
    end else begin
      wr_ent = '{owned: 1'b1, owner: rd_ent.owner, ovl: 1'b1};
    end
    ram_we    = cmd.sweep || s2_write;
    ram_waddr = cmd.sweep ? sweep_cnt : s2_pos;
    ram_raddr = cmd.walk ? cur_pos[cbom_pkg::ADDR_W-1:0] : item_pos;
  end

  cbom_ram #(
    .WIDTH (cbom_pkg::ENTRY_W),
    .DEPTH (cbom_pkg::MAX_FRAME_BITS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_ent),
    .re    (cmd.walk || cmd.rd_issue),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  logic [cbom_pkg::CNT_W-1:0] used_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.accept && cbom_pkg::kind_t'(kind) == cbom_pkg::KIND_CLEAR) begin
      used_count <= '0;
    end else if (s2_new) begin
      used_count <= used_count + 1'b1;
    end
  end

  // result register
  logic rd_hit;

  always_comb begin
    rd_hit = (item_kind == cbom_pkg::KIND_READ) &&
             (cbom_pkg::CNT_W'(item_pos) < total);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      owner_valid <= rd_hit && rd_ent.owned;
      owner_index <= (rd_hit && rd_ent.owned) ? rd_ent.owner : '0;
      overlap     <= rd_hit && rd_ent.ovl;
      used_bits   <= used_count;
    end
  end

  always_comb begin
    sts.kind       = cbom_pkg::kind_t'(kind);
    sts.add_skip   = (bit_length == '0) || hidden ||
                     ({1'b0, signal_index} >= (cbom_pkg::IDX_W + 1)'(cbom_pkg::MAX_SIGNALS));
    sts.walk_last  = (remaining == cbom_pkg::LEN_W'(1));
    sts.sweep_last = &sweep_cnt;
    sts.out_busy   = out_valid && !out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= cbom_pkg::CNT_W'(cbom_pkg::MAX_FRAME_BITS))
    else $error("used count beyond frame size");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep && s2_valid))
    else $error("claim write during clearing sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && out_valid && !out_ready))
    else $error("result register loaded while a beat is pending");

endmodule

// ===== design/can_signal_bit_occupancy_map_core.sv =====
// ----------------------------------------------------------------------------
// can_signal_bit_occupancy_map_core
// Per-bit ownership map of one CAN frame built from signal descriptors.
// ----------------------------------------------------------------------------
// Channel   Handshake               Beat contents
// input     in_valid / in_ready     kind, descriptor fields, bit_position
// output    out_valid / out_ready   owner_valid, owner_index, overlap, used_bits
// config    cfg_we                  cfg_index, cfg_data
//
// Add: min(bit_length, 512) map positions, one per cycle through the
// read-modify-write of the single map RAM; hidden or empty adds skip the
// walk. Read: one RAM read; unused kinds go straight to the result. Clear:
// one entry per cycle. After reset a clearing pass runs before in_ready rises.
// A stalled result holds the block in its final cycle until the beat is taken.
// ----------------------------------------------------------------------------
module can_signal_bit_occupancy_map_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cbom_pkg::CFGI_W-1:0]  cfg_index,
  input  logic [cbom_pkg::MUXV_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   kind,
  input  logic [cbom_pkg::IDX_W-1:0]   signal_index,
  input  logic [8:0]                   start_bit,
  input  logic [cbom_pkg::LEN_W-1:0]   bit_length,
  input  logic                         big_endian,
  input  logic [1:0]                   mux_type,
  input  logic [cbom_pkg::MUXV_W-1:0]  mux_value,
  input  logic [cbom_pkg::ADDR_W-1:0]  bit_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         owner_valid,
  output logic [cbom_pkg::IDX_W-1:0]   owner_index,
  output logic                         overlap,
  output logic [cbom_pkg::CNT_W-1:0]   used_bits
);

  cbom_pkg::cmd_t cmd;
  cbom_pkg::sts_t sts;

  cbom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbom_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .kind         (kind),
    .signal_index (signal_index),
    .start_bit    (start_bit),
    .bit_length   (bit_length),
    .big_endian   (big_endian),
    .mux_type     (mux_type),
    .mux_value    (mux_value),
    .bit_position (bit_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .owner_valid  (owner_valid),
    .owner_index  (owner_index),
    .overlap      (overlap),
    .used_bits    (used_bits),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== tb/can_signal_bit_occupancy_map_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// can_signal_bit_occupancy_map_core_test
// Self-checking bench for the CAN bit occupancy map. Descriptor, clear and
// read beats go in with random bursts and gaps. A local bit-map model
// predicts every result beat, and the checker compares each one as it comes
// out under a stalling receiver.
// ----------------------------------------------------------------------------
module can_signal_bit_occupancy_map_core_test;

  localparam logic [1:0] KIND_SPARE = 2'd3;  // no operation, reports count only
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_DEPTH   = 64;

  typedef struct {
    logic [1:0]                  kind;
    logic [cbom_pkg::IDX_W-1:0]  sig;
    logic [8:0]                  start;
    logic [cbom_pkg::LEN_W-1:0]  len;
    logic                        big;
    logic [1:0]                  mtype;
    logic [cbom_pkg::MUXV_W-1:0] mval;
    logic [cbom_pkg::ADDR_W-1:0] pos;
  } map_op_t;

  typedef struct {
    logic                        owned;
    logic [cbom_pkg::IDX_W-1:0]  owner;
    logic                        ovl;
    logic [cbom_pkg::CNT_W-1:0]  used;
  } bit_report_t;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_BLOCKED} rx_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [cbom_pkg::CFGI_W-1:0]   cfg_index = '0;
  logic [cbom_pkg::MUXV_W-1:0]   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [1:0]                    kind = '0;
  logic [cbom_pkg::IDX_W-1:0]    signal_index = '0;
  logic [8:0]                    start_bit = '0;
  logic [cbom_pkg::LEN_W-1:0]    bit_length = '0;
  logic                          big_endian = 1'b0;
  logic [1:0]                    mux_type = '0;
  logic [cbom_pkg::MUXV_W-1:0]   mux_value = '0;
  logic [cbom_pkg::ADDR_W-1:0]   bit_position = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          owner_valid;
  logic [cbom_pkg::IDX_W-1:0]    owner_index;
  logic                          overlap;
  logic [cbom_pkg::CNT_W-1:0]    used_bits;

  can_signal_bit_occupancy_map_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the map and registers
  logic                        map_owned [cbom_pkg::MAX_FRAME_BITS];
  logic [cbom_pkg::IDX_W-1:0]  map_owner [cbom_pkg::MAX_FRAME_BITS];
  logic                        map_ovl   [cbom_pkg::MAX_FRAME_BITS];
  int                          map_used;
  logic [6:0]                  cfg_frame_bytes = 7'd8;
  logic                        cfg_show_all = 1'b1;
  logic [cbom_pkg::MUXV_W-1:0] cfg_sel_mux = '0;

  // Expected result beats, oldest at rep_rd
  bit_report_t report_fifo [REPORT_DEPTH];
  int          rep_wr = 0;
  int          rep_rd = 0;
  int          n_bad = 0;
  int          burst_left = 0;

  function automatic void clear_map();
    for (int i = 0; i < cbom_pkg::MAX_FRAME_BITS; i++) begin
      map_owned[i] = 1'b0;
      map_owner[i] = '0;
      map_ovl[i]   = 1'b0;
    end
    map_used = 0;
  endfunction

  function automatic int frame_bit_count();
    int total;
    total = int'(cfg_frame_bytes) * 8;
    return (total > cbom_pkg::MAX_FRAME_BITS) ? cbom_pkg::MAX_FRAME_BITS : total;
  endfunction

  function automatic void claim_position(int dbc, int total,
                                         logic [cbom_pkg::IDX_W-1:0] who);
    int p;
    p = (dbc / 8) * 8 + 7 - (dbc % 8);
    if (p >= total) return;
    if (!map_owned[p]) begin
      map_owned[p] = 1'b1;
      map_owner[p] = who;
      map_used++;
    end else if (map_owner[p] != who) begin
      map_ovl[p] = 1'b1;
    end
  endfunction

  function automatic bit_report_t apply_map_op(map_op_t op);
    bit_report_t r;
    int total;
    int len;
    int dbc;
    int i;
    logic hidden;
    r = '{default: '0};
    total = frame_bit_count();
    case (op.kind)
      cbom_pkg::KIND_CLEAR: clear_map();
      cbom_pkg::KIND_ADD: begin
        hidden = !cfg_show_all &&
                 (op.mtype == cbom_pkg::MUX_MUXED || op.mtype == cbom_pkg::MUX_BOTH) &&
                 op.mval != cfg_sel_mux;
        if (!hidden) begin
          len = (int'(op.len) > cbom_pkg::LEN_CAP) ? cbom_pkg::LEN_CAP : int'(op.len);
          dbc = int'(op.start);
          for (i = 0; i < len; i++) begin
            if (op.big) begin
              claim_position(dbc, total, op.sig);
              // Motorola order: step down within a byte, then jump to the next byte's MSB
              dbc = (dbc % 8 == 0) ? dbc + 15 : dbc - 1;
            end else begin
              claim_position(int'(op.start) + i, total, op.sig);
            end
          end
        end
      end
      cbom_pkg::KIND_READ: begin
        if (int'(op.pos) < total) begin
          r.owned = map_owned[op.pos];
          r.owner = map_owned[op.pos] ? map_owner[op.pos] : '0;
          r.ovl   = map_ovl[op.pos];
        end
      end
      default: ;
    endcase
    r.used = map_used[cbom_pkg::CNT_W-1:0];
    return r;
  endfunction

  task automatic send_beat(map_op_t op);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    kind         <= op.kind;
    signal_index <= op.sig;
    start_bit    <= op.start;
    bit_length   <= op.len;
    big_endian   <= op.big;
    mux_type     <= op.mtype;
    mux_value    <= op.mval;
    bit_position <= op.pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    report_fifo[rep_wr % REPORT_DEPTH] = apply_map_op(op);
    rep_wr++;
  endtask

  task automatic send_op(logic [1:0] k, logic [cbom_pkg::IDX_W-1:0] sig,
                         logic [8:0] start, logic [cbom_pkg::LEN_W-1:0] len,
                         logic big, logic [1:0] mtype,
                         logic [cbom_pkg::MUXV_W-1:0] mval,
                         logic [cbom_pkg::ADDR_W-1:0] pos);
    map_op_t op;
    op = '{k, sig, start, len, big, mtype, mval, pos};
    send_beat(op);
  endtask

  // Drop valid and let the block run dry before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rep_wr != rep_rd) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cbom_pkg::reg_idx_t idx, logic [cbom_pkg::MUXV_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cbom_pkg::REG_FRAME_BYTES: cfg_frame_bytes = d[6:0];
      cbom_pkg::REG_SHOW_ALL:    cfg_show_all = d[0];
      cbom_pkg::REG_SEL_MUX:     cfg_sel_mux = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_map();
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd0);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd63);
    // beyond the frame
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd511);
  endtask

  task automatic test_byte_orders();
    send_op(cbom_pkg::KIND_ADD, 6'd1, 9'd0, 10'd8, 1'b0, cbom_pkg::MUX_STATIC, 0, 0);
    // overlaps byte 0
    send_op(cbom_pkg::KIND_ADD, 6'd2, 9'd7, 10'd16, 1'b1, cbom_pkg::MUX_STATIC, 0, 0);
    // same owner again
    send_op(cbom_pkg::KIND_ADD, 6'd1, 9'd4, 10'd2, 1'b0, cbom_pkg::MUX_STATIC, 0, 0);
    send_op(cbom_pkg::KIND_ADD, 6'd3, 9'd20, 10'd0, 1'b0, cbom_pkg::MUX_STATIC, 0, 0);
    // runs off the frame
    send_op(cbom_pkg::KIND_ADD, 6'd0, 9'd60, 10'd10, 1'b0, cbom_pkg::MUX_STATIC, 0, 0);
    send_op(cbom_pkg::KIND_ADD, 6'd63, 9'd511, 10'd1023, 1'b1, cbom_pkg::MUX_STATIC,
            16'hFFFF, 0);
    send_op(KIND_SPARE, 6'd5, 9'd3, 10'd3, 1'b1, cbom_pkg::MUX_BOTH, 16'h5555, 9'd3);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd0);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd9);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd56);
  endtask

  task automatic test_clear();
    send_op(cbom_pkg::KIND_CLEAR, 6'h3F, 9'h1FF, 10'h3FF, 1'b1, cbom_pkg::MUX_BOTH,
            16'hFFFF, 9'h1FF);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd0);
  endtask

  task automatic test_mux_filter();
    settle();
    write_reg(cbom_pkg::REG_SHOW_ALL, 16'd0);
    write_reg(cbom_pkg::REG_SEL_MUX, 16'hFFFF);
    send_op(cbom_pkg::KIND_ADD, 6'd4, 9'd16, 10'd4, 1'b0, cbom_pkg::MUX_MUXED, 16'hFFFF, 0);
    // hidden
    send_op(cbom_pkg::KIND_ADD, 6'd5, 9'd24, 10'd4, 1'b0, cbom_pkg::MUX_MUXED, 16'h0000, 0);
    // hidden
    send_op(cbom_pkg::KIND_ADD, 6'd6, 9'd31, 10'd4, 1'b1, cbom_pkg::MUX_BOTH, 16'h0001, 0);
    send_op(cbom_pkg::KIND_ADD, 6'd7, 9'd32, 10'd4, 1'b0, cbom_pkg::MUX_MUXOR, 16'h1234, 0);
    send_op(cbom_pkg::KIND_ADD, 6'd8, 9'd40, 10'd4, 1'b1, cbom_pkg::MUX_STATIC, 16'h0000, 0);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd31);
  endtask

  task automatic test_frame_size();
    settle();
    write_reg(cbom_pkg::REG_FRAME_BYTES, 16'd64);
    write_reg(cbom_pkg::REG_SHOW_ALL, 16'd1);
    write_reg(cbom_pkg::REG_SEL_MUX, 16'd0);
    send_op(cbom_pkg::KIND_ADD, 6'd9, 9'd0, 10'd512, 1'b1, cbom_pkg::MUX_STATIC, 0, 0);
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd511);
    settle();
    write_reg(cbom_pkg::REG_FRAME_BYTES, 16'd0);
    // stored entry hidden by the frame
    send_op(cbom_pkg::KIND_READ, 0, 0, 0, 0, cbom_pkg::MUX_STATIC, 0, 9'd0);
    send_op(cbom_pkg::KIND_ADD, 6'd10, 9'd0, 10'd8, 1'b0, cbom_pkg::MUX_STATIC, 0, 0);
  endtask

  function automatic map_op_t random_map_op();
    map_op_t op;
    int span;
    int r;
    span = (frame_bit_count() > 0) ? frame_bit_count() : 64;
    r = $urandom_range(0, 99);
    if (r < 3)       op.kind = cbom_pkg::KIND_CLEAR;
    else if (r < 6)  op.kind = KIND_SPARE;
    else if (r < 52) op.kind = cbom_pkg::KIND_ADD;
    else             op.kind = cbom_pkg::KIND_READ;
    op.sig   = cbom_pkg::IDX_W'($urandom_range(0, 63));
    op.start = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, span - 1));
    op.len   = ($urandom_range(0, 19) == 0) ? cbom_pkg::LEN_W'($urandom_range(65, 1023))
                                            : cbom_pkg::LEN_W'($urandom_range(0, 64));
    op.big   = 1'($urandom_range(0, 1));
    op.mtype = 2'($urandom_range(0, 3));
    r = $urandom_range(0, 5);
    if (r < 3)       op.mval = cfg_sel_mux;
    else if (r == 3) op.mval = cfg_sel_mux ^ 16'h0001;
    else             op.mval = cbom_pkg::MUXV_W'($urandom_range(0, 65535));
    op.pos   = ($urandom_range(0, 9) == 0) ? cbom_pkg::ADDR_W'($urandom_range(0, 511))
                                           : cbom_pkg::ADDR_W'($urandom_range(0, span - 1));
    return op;
  endfunction

  task automatic test_random_traffic(logic [6:0] fbytes, logic show,
                                     logic [cbom_pkg::MUXV_W-1:0] sel, int n);
    settle();
    write_reg(cbom_pkg::REG_FRAME_BYTES, {9'd0, fbytes});
    write_reg(cbom_pkg::REG_SHOW_ALL, {15'd0, show});
    write_reg(cbom_pkg::REG_SEL_MUX, sel);
    repeat (n) send_beat(random_map_op());
  endtask

  // Receiver: open, choppy and blocked stretches
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold = 0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(64, 256);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(0, 40);
          out_ready <= 1'b1;
        end else begin
          rx_hold--;
          out_ready <= 1'b0;
        end
      end
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    bit_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (rep_wr == rep_rd) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result beat: owner_valid %0d owner_index %0d %s %0d %0d",
                   owner_valid, owner_index, "overlap/used", overlap, used_bits);
      end else begin
        want = report_fifo[rep_rd % REPORT_DEPTH];
        rep_rd++;
        if (owner_valid !== want.owned || owner_index !== want.owner ||
            overlap !== want.ovl || used_bits !== want.used) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch at %0t: expected valid %0d owner %0d ovl %0d used %0d,",
                      " got %0d %0d %0d %0d"},
                     $realtime, want.owned, want.owner, want.ovl, want.used,
                     owner_valid, owner_index, overlap, used_bits);
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    clear_map();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_map();
    test_byte_orders();
    test_clear();
    test_mux_filter();
    test_frame_size();
    test_random_traffic(7'd8, 1'b1, 16'd0, 50);
    test_random_traffic(7'd64, 1'b1, 16'd0, 50);
    test_random_traffic(7'd64, 1'b0, 16'hFFFF, 50);
    test_random_traffic(7'd32, 1'b0, cbom_pkg::MUXV_W'($urandom_range(0, 65535)), 50);
    test_random_traffic(7'd0, 1'b1, 16'd0, 50);
    test_random_traffic(7'd127, 1'b0, 16'd0, 50);
    test_random_traffic(7'd1, 1'b1, 16'hA5A5, 50);
    test_random_traffic(7'd16, 1'b0, cbom_pkg::MUXV_W'($urandom_range(0, 65535)), 50);
    settle();
    if (n_bad == 0 && rep_wr == rep_rd) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
